### hdl/differential_drive_mixer_defines.svh
// assertion macros shared by the mixer rtl
// depends on nothing; included by the modules that carry assertions
`ifndef DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// antecedent implies consequent after the delay given by argument n
`define ASSERT_AFTER(label, clk, rst_n, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("assertion failed: delayed response");

// condition must never hold
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: forbidden condition");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_AFTER(label, clk, rst_n, ante, n, cons)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### hdl/ddm_pkg.sv
// types and constants for the differential drive mixer
// depends on nothing; used by ddm_div and differential_drive_mixer
package ddm_pkg;

	// field widths
	localparam int CMD_W   = 18;
	localparam int SPD_W   = CMD_W + 1;
	localparam int MAG_W   = CMD_W;
	localparam int QMAG_W  = 17;
	localparam int LEVEL_W = 16;

	// pwm full scale
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'd65535;

	// unity in q16
	localparam logic signed [CMD_W-1:0] CMD_POS_ONE = 18'sd65536;
	localparam logic signed [CMD_W-1:0] CMD_NEG_ONE = -18'sd65536;
	localparam logic [MAG_W-1:0]        MAG_ONE     = 18'd65536;
	localparam logic [QMAG_W-1:0]       QMAG_ONE    = 17'd65536;

	// divider layout: fraction bits spread evenly over the stages
	localparam int FRAC_BITS      = 16;
	localparam int DIV_STAGES     = 4;
	localparam int BITS_PER_STAGE = FRAC_BITS / DIV_STAGES;

	typedef logic signed [CMD_W-1:0] cmd_t;
	typedef logic signed [SPD_W-1:0] spd_t;
	typedef logic [MAG_W-1:0]        mag_t;
	typedef logic [QMAG_W-1:0]       qmag_t;
	typedef logic [LEVEL_W-1:0]      level_t;

	// per-item sideband that rides alongside the divider
	typedef struct packed {
		logic l_pos;
		logic l_neg;
		logic r_pos;
		logic r_neg;
		logic scale;
		logic left_max;
		mag_t min_mag;
		mag_t max_mag;
	} div_side_t;

endpackage

### hdl/differential_drive_mixer.sv
// differential drive mixer: each command accepted while enabled yields a result strobe on done from the output register
// throughput one command per cycle; busy is always low and the receiver cannot stall
// pipeline: clamp and mix, magnitude and max, four divider stages, level mapping
// arst_n clears drive_enable and all pipeline valid bits; commands taken while disabled vanish
// depends on ddm_pkg, ddm_div and differential_drive_mixer_defines.svh
`include "differential_drive_mixer_defines.svh"

module differential_drive_mixer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ddm_pkg::cmd_t   forward_cmd,
	input  ddm_pkg::cmd_t   turn_cmd,
	input  logic            cfg_we,
	input  logic            cfg_wdata,
	output logic            done,
	output ddm_pkg::level_t left_a_level,
	output ddm_pkg::level_t left_b_level,
	output ddm_pkg::level_t right_a_level,
	output ddm_pkg::level_t right_b_level
);
	import ddm_pkg::*;

	function automatic cmd_t clamp_one(cmd_t v);
		if (v < CMD_NEG_ONE) begin
			return CMD_NEG_ONE;
		end
		if (v > CMD_POS_ONE) begin
			return CMD_POS_ONE;
		end
		return v;
	endfunction

	function automatic level_t level_of(qmag_t m);
		logic [QMAG_W+LEVEL_W-1:0] p;
		p = (QMAG_W+LEVEL_W)'(m) * (QMAG_W+LEVEL_W)'(LEVEL_MAX);
		return p[LEVEL_W+15:16];
	endfunction

	logic drive_enable_q;
	logic accept;

	logic valid_s1;
	spd_t left_s1;
	spd_t right_s1;

	logic      valid_s2;
	div_side_t side_s2;

	logic      div_valid;
	div_side_t div_side;
	qmag_t     div_quo;

	logic   done_q;
	level_t left_a_q;
	level_t left_b_q;
	level_t right_a_q;
	level_t right_b_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_enable_q <= 1'b0;
		end else if (cfg_we) begin
			drive_enable_q <= cfg_wdata;
		end
	end

	// stage 1: clamp and mix
	cmd_t fwd_c;
	cmd_t trn_c;

	always_comb begin
		fwd_c = clamp_one(forward_cmd);
		trn_c = clamp_one(turn_cmd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && drive_enable_q;
		end
	end

	always_ff @(posedge clk) begin
		left_s1  <= spd_t'(fwd_c) - spd_t'(trn_c);
		right_s1 <= spd_t'(fwd_c) + spd_t'(trn_c);
	end

	// stage 2: magnitudes, larger one, scale decision
	spd_t      l_negv;
	spd_t      r_negv;
	mag_t      l_mag;
	mag_t      r_mag;
	div_side_t side_d;

	always_comb begin
		l_negv = -left_s1;
		r_negv = -right_s1;
		l_mag  = left_s1[SPD_W-1]  ? l_negv[MAG_W-1:0] : left_s1[MAG_W-1:0];
		r_mag  = right_s1[SPD_W-1] ? r_negv[MAG_W-1:0] : right_s1[MAG_W-1:0];
		side_d.l_pos    = !left_s1[SPD_W-1] && (left_s1 != '0);
		side_d.l_neg    = left_s1[SPD_W-1];
		side_d.r_pos    = !right_s1[SPD_W-1] && (right_s1 != '0);
		side_d.r_neg    = right_s1[SPD_W-1];
		side_d.left_max = l_mag >= r_mag;
		side_d.max_mag  = side_d.left_max ? l_mag : r_mag;
		side_d.min_mag  = side_d.left_max ? r_mag : l_mag;
		side_d.scale    = side_d.max_mag > MAG_ONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_d;
	end

	// stages 3 to 6: scale the smaller magnitude by the larger
	ddm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_side   (side_s2),
		.out_valid (div_valid),
		.out_side  (div_side),
		.out_quo   (div_quo)
	);

	// stage 7: pick magnitudes, map to levels, steer onto the bridge pins
	qmag_t  max_sel;
	qmag_t  min_sel;
	level_t l_lev;
	level_t r_lev;

	always_comb begin
		max_sel = div_side.scale ? QMAG_ONE : div_side.max_mag[QMAG_W-1:0];
		min_sel = div_side.scale ? div_quo  : div_side.min_mag[QMAG_W-1:0];
		l_lev   = level_of(div_side.left_max ? max_sel : min_sel);
		r_lev   = level_of(div_side.left_max ? min_sel : max_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		left_a_q  <= div_side.l_pos ? l_lev : '0;
		left_b_q  <= div_side.l_neg ? l_lev : '0;
		right_b_q <= div_side.r_pos ? r_lev : '0;
		right_a_q <= div_side.r_neg ? r_lev : '0;
	end

	assign done          = done_q;
	assign left_a_level  = left_a_q;
	assign left_b_level  = left_b_q;
	assign right_a_level = right_a_q;
	assign right_b_level = right_b_q;

	// an enabled transfer always yields a result on done
	`ASSERT_AFTER(a_latency, clk, arst_n, accept && drive_enable_q, 7, done)
	// a result only follows an enabled transfer
	`ASSERT_IMPLIES(a_no_spurious, clk, arst_n, done, $past(accept && drive_enable_q, 7))
	// a motor never drives both bridge pins at once
	`ASSERT_NEVER(a_bridge_excl, clk, arst_n,
		done && ((left_a_level != '0 && left_b_level != '0) ||
		(right_a_level != '0 && right_b_level != '0)))

endmodule

### hdl/ddm_div.sv
// pipelined fraction divider: min_mag * 65536 / max_mag, restoring, 4 bits per stage
// depends on ddm_pkg and differential_drive_mixer_defines.svh
`include "differential_drive_mixer_defines.svh"

module ddm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ddm_pkg::div_side_t in_side,
	output logic              out_valid,
	output ddm_pkg::div_side_t out_side,
	output ddm_pkg::qmag_t    out_quo
);
	import ddm_pkg::*;

	logic      vld_s  [DIV_STAGES];
	mag_t      rem_s  [DIV_STAGES];
	qmag_t     quo_s  [DIV_STAGES];
	div_side_t side_s [DIV_STAGES];

	logic      vld_in  [DIV_STAGES];
	mag_t      rem_in  [DIV_STAGES];
	qmag_t     quo_in  [DIV_STAGES];
	div_side_t side_in [DIV_STAGES];

	// integer quotient bit, set only when both magnitudes are equal
	logic int_bit;
	mag_t int_diff;

	always_comb begin
		int_bit  = in_side.min_mag >= in_side.max_mag;
		int_diff = in_side.min_mag - in_side.max_mag;
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		mag_t  r [BITS_PER_STAGE+1];
		qmag_t q [BITS_PER_STAGE+1];

		// stage inputs
		if (k == 0) begin : g_first
			assign vld_in[k]  = in_valid;
			assign side_in[k] = in_side;
			assign rem_in[k]  = int_bit ? int_diff : in_side.min_mag;
			assign quo_in[k]  = QMAG_W'(int_bit);
		end else begin : g_next
			assign vld_in[k]  = vld_s[k-1];
			assign side_in[k] = side_s[k-1];
			assign rem_in[k]  = rem_s[k-1];
			assign quo_in[k]  = quo_s[k-1];
		end

		// shift-compare-subtract steps
		always_comb begin
			logic [MAG_W:0] t;
			logic [MAG_W:0] d;
			logic           ge;
			r[0] = rem_in[k];
			q[0] = quo_in[k];
			for (int j = 0; j < BITS_PER_STAGE; j++) begin
				t  = {r[j], 1'b0};
				ge = t >= {1'b0, side_in[k].max_mag};
				d  = t - {1'b0, side_in[k].max_mag};
				r[j+1] = ge ? d[MAG_W-1:0] : t[MAG_W-1:0];
				q[j+1] = {q[j][QMAG_W-2:0], ge};
			end
		end

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in[k];
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			rem_s[k]  <= r[BITS_PER_STAGE];
			quo_s[k]  <= q[BITS_PER_STAGE];
			side_s[k] <= side_in[k];
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];
	assign out_quo   = quo_s[DIV_STAGES-1];

	// a scaled quotient never exceeds unity
	`ASSERT_IMPLIES(a_quo_range, clk, arst_n, out_valid && out_side.scale, out_quo <= QMAG_ONE)
	// full-scale quotient only when the smaller magnitude equals the larger
	`ASSERT_IMPLIES(a_quo_unity, clk, arst_n, out_valid && out_side.scale && out_quo[QMAG_W-1],
		out_side.min_mag == out_side.max_mag)

endmodule

### tb/tb.sv
// self-checking testbench for differential_drive_mixer: arcade mixing and h-bridge level mapping
// depends on ddm_pkg and the differential_drive_mixer rtl; the scoreboard predicts every level
module tb;
	import ddm_pkg::*;

	// the four pin levels of one result
	typedef struct packed {
		level_t left_a;
		level_t left_b;
		level_t right_a;
		level_t right_b;
	} drive_levels_t;

	// scoreboard: predicts the pin levels of each command accepted while enabled and checks results in order
	class drive_level_board;
		drive_levels_t pending_levels[$];
		bit            drive_on;
		int            errors;
		int            commands_seen;
		int            results_checked;

		function new();
			drive_on = 1'b0;
			errors = 0;
			commands_seen = 0;
			results_checked = 0;
		endfunction

		task report(string what, longint got, longint want);
			errors++;
			$display("tb: mismatch on %s, got %0d, want %0d", what, got, want);
		endtask

		function longint clamp_unity(cmd_t raw);
			longint v;
			v = raw;
			if (v > 65536) v = 65536;
			if (v < -65536) v = -65536;
			return v;
		endfunction

		function longint level_from_mag(longint m);
			return (m * longint'(LEVEL_MAX)) >>> 16;
		endfunction

		// clamp, mix, normalize by the larger magnitude when it exceeds unity, then steer each level by the speed sign
		function drive_levels_t predict_levels(cmd_t fwd_raw, cmd_t trn_raw);
			longint fwd, trn, left, right, lmag, rmag, peak;
			drive_levels_t lv;
			fwd = clamp_unity(fwd_raw);
			trn = clamp_unity(trn_raw);
			left = fwd - trn;
			right = fwd + trn;
			lmag = (left < 0) ? -left : left;
			rmag = (right < 0) ? -right : right;
			peak = (lmag > rmag) ? lmag : rmag;
			if (peak > 65536) begin
				lmag = (lmag * 65536) / peak;
				rmag = (rmag * 65536) / peak;
			end
			lv = '0;
			if (left > 0 && lmag != 0)
				lv.left_a = level_t'(level_from_mag(lmag));
			else if (left < 0 && lmag != 0)
				lv.left_b = level_t'(level_from_mag(lmag));
			if (right > 0 && rmag != 0)
				lv.right_b = level_t'(level_from_mag(rmag));
			else if (right < 0 && rmag != 0)
				lv.right_a = level_t'(level_from_mag(rmag));
			return lv;
		endfunction

		function void set_enable(bit v);
			drive_on = v;
		endfunction

		// a command taken while disabled produces nothing
		function void note_command(cmd_t fwd, cmd_t trn);
			if (drive_on) begin
				pending_levels.push_back(predict_levels(fwd, trn));
				commands_seen++;
			end
		endfunction

		task check_levels(drive_levels_t got);
			drive_levels_t want;
			if (pending_levels.size() == 0) begin
				report("result with no command waiting", 0, 0);
			end else begin
				want = pending_levels.pop_front();
				results_checked++;
				if (got.left_a !== want.left_a) report("left_a_level", got.left_a, want.left_a);
				if (got.left_b !== want.left_b) report("left_b_level", got.left_b, want.left_b);
				if (got.right_a !== want.right_a)
					report("right_a_level", got.right_a, want.right_a);
				if (got.right_b !== want.right_b)
					report("right_b_level", got.right_b, want.right_b);
			end
		endtask

		function int outstanding();
			return pending_levels.size();
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	cmd_t   forward_cmd;
	cmd_t   turn_cmd;
	logic   cfg_we;
	logic   cfg_wdata;
	logic   done;
	level_t left_a_level;
	level_t left_b_level;
	level_t right_a_level;
	level_t right_b_level;

	drive_level_board sb = new();
	int unsigned      idle_pct;
	int               dropped_commands;

	differential_drive_mixer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.forward_cmd   (forward_cmd),
		.turn_cmd      (turn_cmd),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.done          (done),
		.left_a_level  (left_a_level),
		.left_b_level  (left_b_level),
		.right_a_level (right_a_level),
		.right_b_level (right_b_level)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		#2000000;
		$display("tb: errors");
		$finish;
	end

	// monitor: command transfers, register writes and result strobes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				if (!sb.drive_on) dropped_commands++;
				sb.note_command(forward_cmd, turn_cmd);
			end
			if (cfg_we) sb.set_enable(cfg_wdata);
			if (done) sb.check_levels({left_a_level, left_b_level, right_a_level, right_b_level});
		end
	end

	// one command transfer, with random idle cycles ahead of it
	task send_command(cmd_t fwd, cmd_t trn);
		bit taken;
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			forward_cmd = cmd_t'($urandom);
			turn_cmd = cmd_t'($urandom);
			@(negedge clk);
		end
		start = 1'b1;
		forward_cmd = fwd;
		turn_cmd = trn;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end
	endtask

	// register write once every result is in and the pipeline has drained
	task write_enable(bit v);
		start = 1'b0;
		while (sb.outstanding() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
	endtask

	// random command: mostly in range, with extremes, near-unity and near-zero values
	function cmd_t pick_cmd();
		int v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = int'($urandom_range(131072)) - 65536;
			4, 5:       v = int'($urandom);
			6: begin
				case ($urandom_range(5))
					0: v = 0;
					1: v = 65536;
					2: v = -65536;
					3: v = 131071;
					4: v = -131072;
					default: v = 65537;
				endcase
			end
			7:       v = int'($urandom_range(600)) - 300;
			default: v = ($urandom_range(1) ? 65536 : -65536) + int'($urandom_range(8)) - 4;
		endcase
		return cmd_t'(v);
	endfunction

	task random_commands(int count);
		cmd_t fwd, trn;
		for (int i = 0; i < count; i++) begin
			fwd = pick_cmd();
			case ($urandom_range(7))
				0:       trn = fwd;
				1:       trn = -fwd;
				default: trn = pick_cmd();
			endcase
			send_command(fwd, trn);
		end
	endtask

	// edge cases: zero, unity in every direction, clamping past unity, tiny speeds
	int directed_fwd [21] = '{0, 65536, -65536, 0, 0, 65536, 65536, -65536, -65536,
		131071, -131072, 0, 0, 131071, 65537, 32768, 1, 0, -1, 65535, 40000};
	int directed_trn [21] = '{0, 0, 0, 65536, -65536, 65536, -65536, 65536, -65536,
		0, 0, 131071, -131072, -131072, -65537, 16384, 0, 1, -1, 1, 30000};

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		forward_cmd = '0;
		turn_cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		idle_pct = 0;
		dropped_commands = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// disabled after reset: commands must vanish
		random_commands(8);
		write_enable(1'b1);

		// directed, back to back
		for (int i = 0; i < 21; i++)
			send_command(cmd_t'(directed_fwd[i]), cmd_t'(directed_trn[i]));

		idle_pct = 34;
		random_commands(180);

		// disable again, feed a few, re-enable
		write_enable(1'b0);
		random_commands(10);
		write_enable(1'b1);

		idle_pct = 54;
		random_commands(180);

		write_enable(1'b0);
		write_enable(1'b1);

		idle_pct = 0;
		random_commands(190);

		// drain
		start = 1'b0;
		while (sb.outstanding() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		if (sb.outstanding() != 0) sb.report("results never delivered", 0, sb.outstanding());

		$display("tb: %0d enabled commands predicted, %0d results checked, %0d disabled commands",
			sb.commands_seen, sb.results_checked, dropped_commands);
		$display("tb: enable toggled off and on, sender idling at 34, 54 and 0 percent");
		if (sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/ddm_pkg.sv
hdl/ddm_div.sv
hdl/differential_drive_mixer.sv
tb/tb.sv
